### rtl/core/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // Item opcodes.
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;

  // Configuration port and register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'd1;

  localparam logic [3:0] RESET_FOREGROUND = 4'd7;
  localparam logic [3:0] RESET_BACKGROUND = 4'd0;

  // A cell keeps the character in its low byte and the attribute in its high byte.
  localparam int CELL_W = 16;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_BACKGROUND, RESET_FOREGROUND, CHAR_BLANK};

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_COPY,
    ST_FILL,
    ST_PUT,
    ST_CLEAR,
    ST_READ,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_RESET,
    WR_BLANK,
    WR_COPY,
    WR_CHAR
  } wsel_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_COPY,
    RD_CELL
  } rsel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_CLEAR
  } cnt_op_t;

  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_ZERO,
    CUR_INC
  } cur_op_t;

  typedef struct packed {
    logic    latch;
    wsel_t   wsel;
    rsel_t   rsel;
    cnt_op_t cnt_op;
    cur_op_t cur_op;
    logic    capture;
    logic    load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       is_newline;
    logic       is_return;
    logic       cursor_full;
    logic       read_in_range;
    logic       copy_first;
    logic       copy_last;
    logic       sweep_last;
  } tcw_status_t;

endpackage

`default_nettype wire

### rtl/core/tcw_in_if.sv
`default_nettype none

interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] character;
  logic [4:0] read_row;
  logic [6:0] read_column;

  modport source (output valid, output opcode, output character, output read_row,
                  output read_column, input ready);
  modport sink (input valid, input opcode, input character, input read_row,
                input read_column, output ready);
endinterface

`default_nettype wire

### rtl/core/tcw_out_if.sv
`default_nettype none

interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_character;
  logic [7:0] cell_attribute;
  logic [6:0] cursor_column;

  modport source (output valid, output cell_character, output cell_attribute,
                  output cursor_column, input ready);
  modport sink (input valid, input cell_character, input cell_attribute,
                input cursor_column, output ready);
endinterface

`default_nettype wire

### rtl/core/text_console_writer_core.sv
// Each item gives one result beat: a printable character, a carriage return and a cell read
// alike. A scroll and a clear sweep the screen cell by cell, and the read of the screen
// memory is registered.
// Throughput: one item at a time; a new beat is taken in the cycle after the last result loads.
// Reset: synchronous, active high; a sweep over all ROWS*COLUMNS cells then fills the screen
// with blanks in attribute 0x07 and no input beat is taken until it ends.
`default_nettype none

module text_console_writer_core #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data,
  tcw_in_if.sink                               item,
  tcw_out_if.source                            result
);

  import tcw_pkg::*;

  // The controller sequences every item: it decodes the opcode, runs the sweeps
  // that scroll or clear the screen, and owns the valid flag of the result register.
  // The datapath holds the screen memory, the cursor, the colours and the sweep counter.
  tcw_cmd_t    cmd;
  tcw_status_t status;
  logic        item_ready;
  logic        out_valid;

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item_ready),
    .out_valid  (out_valid),
    .out_ready  (result.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // A scroll reads each cell one row down and writes it in the next cycle one row up,
  // then blanks the bottom row in the current colours. A character that finds the
  // row full is written at column zero after that scroll.
  tcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (item.opcode),
    .character      (item.character),
    .read_row       (item.read_row),
    .read_column    (item.read_column),
    .cell_character (result.cell_character),
    .cell_attribute (result.cell_attribute),
    .cursor_column  (result.cursor_column)
  );

  // The result register parts the two sides: an input beat is taken while an
  // earlier result still waits, and the item then holds only at its last step.
  assign item.ready   = item_ready;
  assign result.valid = out_valid;

endmodule

`default_nettype wire

### rtl/core/tcw_ram.sv
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t         cmd
);

  import tcw_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (status.opcode)
          OP_PUT: begin
            if (status.cursor_full || status.is_newline) begin
              state_next = ST_COPY;
            end else if (status.is_return) begin
              state_next = ST_DONE;
            end else begin
              state_next = ST_PUT;
            end
          end
          OP_CLEAR: state_next = ST_CLEAR;
          OP_READ:  state_next = status.read_in_range ? ST_READ : ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_COPY: begin
        if (status.copy_last) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (status.sweep_last) begin
          state_next = (status.is_newline || status.is_return) ? ST_DONE : ST_PUT;
        end
      end
      ST_PUT:      state_next = ST_DONE;
      ST_CLEAR: begin
        if (status.sweep_last) state_next = ST_DONE;
      end
      ST_READ:     state_next = ST_READ_CAP;
      ST_READ_CAP: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.wsel   = WR_NONE;
    cmd.rsel   = RD_NONE;
    cmd.cnt_op = CNT_HOLD;
    cmd.cur_op = CUR_HOLD;
    item_ready = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.wsel   = WR_RESET;
        cmd.cnt_op = status.sweep_last ? CNT_CLEAR : CNT_INC;
      end
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.latch  = 1'b1;
          cmd.cnt_op = CNT_CLEAR;
        end
      end
      ST_DISPATCH: begin
        if (status.opcode == OP_PUT && !status.cursor_full && !status.is_newline &&
            status.is_return) begin
          cmd.cur_op = CUR_ZERO;
        end
      end
      ST_COPY: begin
        cmd.rsel   = status.copy_last ? RD_NONE : RD_COPY;
        cmd.wsel   = status.copy_first ? WR_NONE : WR_COPY;
        cmd.cnt_op = status.copy_last ? CNT_HOLD : CNT_INC;
      end
      ST_FILL: begin
        cmd.wsel = WR_BLANK;
        if (status.sweep_last) begin
          cmd.cnt_op = CNT_CLEAR;
          cmd.cur_op = CUR_ZERO;
        end else begin
          cmd.cnt_op = CNT_INC;
        end
      end
      ST_PUT: begin
        cmd.wsel   = WR_CHAR;
        cmd.cur_op = CUR_INC;
      end
      ST_CLEAR: begin
        cmd.wsel   = WR_BLANK;
        cmd.cnt_op = status.sweep_last ? CNT_CLEAR : CNT_INC;
      end
      ST_READ: begin
        cmd.rsel = RD_CELL;
      end
      ST_READ_CAP: begin
        cmd.capture = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd.wsel = WR_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tcw_datapath.sv
`default_nettype none

module tcw_datapath #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tcw_pkg::tcw_cmd_t                 cmd,
  output tcw_pkg::tcw_status_t                   status,
  input  wire logic                              cfg_write,
  input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [1:0]                        opcode,
  input  wire logic [7:0]                        character,
  input  wire logic [4:0]                        read_row,
  input  wire logic [6:0]                        read_column,
  output logic      [7:0]                        cell_character,
  output logic      [7:0]                        cell_attribute,
  output logic      [6:0]                        cursor_column
);

  import tcw_pkg::*;

  localparam int CELLS       = ROWS * COLUMNS;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(COLUMNS + 1);
  localparam int COPY_END    = CELLS - COLUMNS;
  localparam int BOTTOM_BASE = (ROWS - 1) * COLUMNS;

  logic [1:0]        pend_opcode;
  logic [7:0]        pend_character;
  logic [4:0]        pend_row;
  logic [6:0]        pend_column;
  logic [3:0]        foreground;
  logic [3:0]        background;
  logic [CW-1:0]     cursor;
  logic [AW-1:0]     cnt;
  logic [7:0]        result_character;
  logic [7:0]        result_attribute;

  logic [7:0]        attribute;
  logic [CELL_W-1:0] blank_cell;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [AW-1:0]     cell_addr;

  assign attribute  = {background, foreground};
  assign blank_cell = {attribute, CHAR_BLANK};
  assign cell_addr  = AW'(32'(pend_row) * COLUMNS + 32'(pend_column));

  // Item and colour registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      foreground <= RESET_FOREGROUND;
      background <= RESET_BACKGROUND;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FOREGROUND: foreground <= cfg_data;
        REG_BACKGROUND: background <= cfg_data;
        default:        foreground <= foreground;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      pend_opcode      <= opcode;
      pend_character   <= character;
      pend_row         <= read_row;
      pend_column      <= read_column;
      result_character <= '0;
      result_attribute <= '0;
    end else if (cmd.capture) begin
      result_character <= ram_rdata[7:0];
      result_attribute <= ram_rdata[15:8];
    end
    if (cmd.load_out) begin
      cell_character <= result_character;
      cell_attribute <= result_attribute;
      cursor_column  <= 7'(cursor);
    end
  end

  // Cursor and sweep counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      cnt    <= '0;
    end else begin
      case (cmd.cur_op)
        CUR_ZERO: cursor <= '0;
        CUR_INC:  cursor <= cursor + 1'b1;
        default:  cursor <= cursor;
      endcase
      case (cmd.cnt_op)
        CNT_INC:   cnt <= cnt + 1'b1;
        CNT_CLEAR: cnt <= '0;
        default:   cnt <= cnt;
      endcase
    end
  end

  // Memory port selection. During a scroll each cell that is read is
  // written one row higher in the next cycle.
  always_comb begin
    ram_we    = cmd.wsel != WR_NONE;
    ram_waddr = cnt;
    ram_wdata = blank_cell;
    case (cmd.wsel)
      WR_RESET: ram_wdata = RESET_CELL;
      WR_BLANK: ram_wdata = blank_cell;
      WR_COPY: begin
        ram_waddr = cnt - 1'b1;
        ram_wdata = ram_rdata;
      end
      WR_CHAR: begin
        ram_waddr = AW'(BOTTOM_BASE) + AW'(cursor);
        ram_wdata = {attribute, pend_character};
      end
      default: ram_wdata = blank_cell;
    endcase
  end

  always_comb begin
    case (cmd.rsel)
      RD_COPY: ram_raddr = cnt + AW'(COLUMNS);
      RD_CELL: ram_raddr = cell_addr;
      default: ram_raddr = '0;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    status.opcode        = pend_opcode;
    status.is_newline    = pend_character == CHAR_NEWLINE;
    status.is_return     = pend_character == CHAR_RETURN;
    status.cursor_full   = 32'(cursor) >= COLUMNS;
    status.read_in_range = (32'(pend_row) < ROWS) && (32'(pend_column) < COLUMNS);
    status.copy_first    = cnt == '0;
    status.copy_last     = cnt == AW'(COPY_END);
    status.sweep_last    = cnt == AW'(CELLS - 1);
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(ram_waddr) < CELLS)
    else $error("screen write outside the cell store");

  a_char_below_full: assert property (@(posedge clk) disable iff (rst)
    cmd.wsel == WR_CHAR |-> 32'(cursor) < COLUMNS)
    else $error("character written with the cursor past the row");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cursor) <= COLUMNS)
    else $error("cursor beyond the row length");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rsel == RD_CELL |-> status.read_in_range)
    else $error("cell read issued for a position off the screen");

  a_copy_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wsel == WR_COPY |-> $past(cmd.rsel) == RD_COPY)
    else $error("scroll write without the read one cycle earlier");

endmodule

`default_nettype wire
